// ===== rtl/core/ctgr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctgr_pkg
// shared types, register codes and white-point tables of the gamma ramp block
// ----------------------------------------------------------------------------
package ctgr_pkg;

  localparam logic [16:0] Q16One = 17'd65536;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS  = 2'd0,
    REG_TEMPERATURE = 2'd1,
    REG_RAMP_LEN    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [16:0] green;
    logic [16:0] blue;
  } factors_t;

  function automatic logic [16:0] green_row(input logic [7:0] row);
    logic [16:0] v;
    case (row)
      8'd0: v = 17'd11910;  8'd1: v = 17'd16714;  8'd2: v = 17'd20278;
      8'd3: v = 17'd23172;  8'd4: v = 17'd25619;  8'd5: v = 17'd27737;
      8'd6: v = 17'd29596;  8'd7: v = 17'd31245;  8'd8: v = 17'd32718;
      8'd9: v = 17'd34042;  8'd10: v = 17'd35625; 8'd11: v = 17'd37106;
      8'd12: v = 17'd38493; 8'd13: v = 17'd39796; 8'd14: v = 17'd41026;
      8'd15: v = 17'd42188; 8'd16: v = 17'd43288; 8'd17: v = 17'd44332;
      8'd18: v = 17'd45325; 8'd19: v = 17'd46270; 8'd20: v = 17'd47171;
      8'd21: v = 17'd48031; 8'd22: v = 17'd48852; 8'd23: v = 17'd49637;
      8'd24: v = 17'd50390; 8'd25: v = 17'd51110; 8'd26: v = 17'd51801;
      8'd27: v = 17'd52464; 8'd28: v = 17'd53100; 8'd29: v = 17'd53712;
      8'd30: v = 17'd54300; 8'd31: v = 17'd54865; 8'd32: v = 17'd55410;
      8'd33: v = 17'd55934; 8'd34: v = 17'd56438; 8'd35: v = 17'd56925;
      8'd36: v = 17'd57394; 8'd37: v = 17'd57847; 8'd38: v = 17'd58284;
      8'd39: v = 17'd58705; 8'd40: v = 17'd59112; 8'd41: v = 17'd59614;
      8'd42: v = 17'd60104; 8'd43: v = 17'd60583; 8'd44: v = 17'd61051;
      8'd45: v = 17'd61508; 8'd46: v = 17'd61955; 8'd47: v = 17'd62391;
      8'd48: v = 17'd62818; 8'd49: v = 17'd63234; 8'd50: v = 17'd63640;
      8'd51: v = 17'd64037; 8'd52: v = 17'd64425; 8'd53: v = 17'd64804;
      8'd54: v = 17'd65174;
      default: v = Q16One;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] blue_row(input logic [7:0] row);
    logic [16:0] v;
    case (row)
      8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9: v = 17'd0;
      8'd10: v = 17'd5688;  8'd11: v = 17'd9218;  8'd12: v = 17'd12034;
      8'd13: v = 17'd14508; 8'd14: v = 17'd16772; 8'd15: v = 17'd18887;
      8'd16: v = 17'd20889; 8'd17: v = 17'd22798; 8'd18: v = 17'd24628;
      8'd19: v = 17'd26389; 8'd20: v = 17'd28089; 8'd21: v = 17'd29732;
      8'd22: v = 17'd31322; 8'd23: v = 17'd32863; 8'd24: v = 17'd34359;
      8'd25: v = 17'd35810; 8'd26: v = 17'd37220; 8'd27: v = 17'd38590;
      8'd28: v = 17'd39923; 8'd29: v = 17'd41218; 8'd30: v = 17'd42478;
      8'd31: v = 17'd43704; 8'd32: v = 17'd44898; 8'd33: v = 17'd46060;
      8'd34: v = 17'd47191; 8'd35: v = 17'd48293; 8'd36: v = 17'd49366;
      8'd37: v = 17'd50411; 8'd38: v = 17'd51430; 8'd39: v = 17'd52422;
      8'd40: v = 17'd53389; 8'd41: v = 17'd54289; 8'd42: v = 17'd55175;
      8'd43: v = 17'd56049; 8'd44: v = 17'd56909; 8'd45: v = 17'd57757;
      8'd46: v = 17'd58592; 8'd47: v = 17'd59414; 8'd48: v = 17'd60224;
      8'd49: v = 17'd61020; 8'd50: v = 17'd61804; 8'd51: v = 17'd62576;
      8'd52: v = 17'd63335; 8'd53: v = 17'd64081; 8'd54: v = 17'd64815;
      default: v = Q16One;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ctgr_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctgr_setup
// configuration registers and a multi-cycle unit that derives the clamped
// brightness, ramp step and interpolated channel factors
// ----------------------------------------------------------------------------
module ctgr_setup #(
  parameter int TABLE_ROWS       = 56,
  parameter int BRIGHT_STEPS_MAX = 500,
  parameter int KELVIN_LO        = 1000,
  parameter int KELVIN_HI        = 6500
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [16:0]       cfg_data,
  output logic [15:0]            bright_eff,
  output logic [16:0]            step,
  output ctgr_pkg::factors_t     factors,
  output logic                   busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE
  } state_t;

  localparam int Span = (KELVIN_HI > KELVIN_LO) ? (KELVIN_HI - KELVIN_LO) : 1;
  localparam longint unsigned Scale = 64'(TABLE_ROWS - 1) << 16;
  localparam logic [23:0] PosWhole = 24'(Scale / Span);
  localparam logic [15:0] PosRem = 16'(Scale % Span);
  localparam logic [29:0] SpanRecip = 30'((64'd1 << 29) / Span);
  localparam logic [15:0] BMax = 16'(BRIGHT_STEPS_MAX);
  localparam logic [15:0] TMin = 16'(KELVIN_LO);
  localparam logic [15:0] TMax = 16'(KELVIN_HI);
  localparam logic [15:0] Rows1 = 16'(TABLE_ROWS - 1);
  localparam logic [15:0] SpanW = 16'(Span);
  localparam bit EmptySpan = (KELVIN_HI <= KELVIN_LO);

  state_t      state;
  logic [8:0]  brightness;
  logic [12:0] temperature;
  logic [16:0] ramp_len;

  // step divider: 65536 / size, restoring, one bit a cycle
  logic [4:0]  sdiv_cnt;
  logic [16:0] sdiv_rem;
  logic [16:0] sdiv_q;
  logic [16:0] sdiv_den;
  logic [17:0] sdiv_trial;

  // table position: whole part of x*scale/span plus reciprocal division of
  // the remainder term with one correction step
  logic [12:0] pos_x;
  logic [28:0] pos_m;
  logic [23:0] pos_xq;
  logic [28:0] pos_qe;
  logic [28:0] pos_r;
  logic [31:0] pos;
  logic [15:0] t_clamp;
  logic [36:0] whole_prod;
  logic [58:0] recip_prod;
  logic [44:0] back_prod;

  logic [7:0]  row;
  logic [16:0] frac;
  logic        row_last;
  logic [16:0] g0, g1, b0, b1;
  logic [33:0] g_sum, b_sum;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);

  always_comb begin
    t_clamp = {3'b0, temperature};
    if (t_clamp < TMin) t_clamp = TMin;
    if (t_clamp > TMax) t_clamp = TMax;
    whole_prod = pos_x * PosWhole;
    recip_prod = pos_m * SpanRecip;
    back_prod = pos_qe * SpanW;
    sdiv_trial = {sdiv_rem, sdiv_q[16]} - {1'b0, sdiv_den};
    row_last = (pos[31:16] >= Rows1);
    row = pos[23:16];
    frac = {1'b0, pos[15:0]};
    g0 = ctgr_pkg::green_row(row);
    g1 = ctgr_pkg::green_row(8'(row + 8'd1));
    b0 = ctgr_pkg::blue_row(row);
    b1 = ctgr_pkg::blue_row(8'(row + 8'd1));
    g_sum = g0 * (ctgr_pkg::Q16One - frac) + g1 * frac;
    b_sum = b0 * (ctgr_pkg::Q16One - frac) + b1 * frac;
  end

  // free-running; a temperature change reaches pos via pos_x, pos_m/pos_xq, pos_qe and pos_r
  always_ff @(posedge clk) begin
    pos_x <= EmptySpan ? 13'd0 : 13'(t_clamp - TMin);
    pos_m <= pos_x * PosRem;
    pos_xq <= whole_prod[23:0];
    pos_qe <= recip_prod[57:29];
    pos_r <= pos_m - back_prod[28:0];
    pos <= {8'b0, pos_xq} + {3'b0, pos_qe} + {31'b0, (pos_r >= {13'b0, SpanW})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      brightness <= 9'd500;
      temperature <= 13'd6500;
      ramp_len <= 17'd2048;
      sdiv_cnt <= '0;
      sdiv_q <= '0;
      sdiv_rem <= '0;
      sdiv_den <= '0;
      bright_eff <= '0;
      step <= '0;
      factors <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctgr_pkg::REG_BRIGHTNESS:  brightness <= cfg_data[8:0];
        ctgr_pkg::REG_TEMPERATURE: temperature <= cfg_data[12:0];
        ctgr_pkg::REG_RAMP_LEN:    ramp_len <= cfg_data;
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD: begin
          sdiv_q <= ctgr_pkg::Q16One;
          sdiv_rem <= '0;
          sdiv_den <= (ramp_len == '0) ? 17'd1 : ramp_len;
          sdiv_cnt <= 5'd17;
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (sdiv_cnt != '0) begin
            if (!sdiv_trial[17]) begin
              sdiv_rem <= sdiv_trial[16:0];
              sdiv_q <= {sdiv_q[15:0], 1'b1};
            end else begin
              sdiv_rem <= {sdiv_rem[15:0], sdiv_q[16]};
              sdiv_q <= {sdiv_q[15:0], 1'b0};
            end
            sdiv_cnt <= sdiv_cnt - 5'd1;
          end else begin
            step <= (ramp_len > ctgr_pkg::Q16One) ? 17'd0 : sdiv_q;
            bright_eff <= ({7'b0, brightness} > BMax) ? BMax : {7'b0, brightness};
            factors.green <= row_last ? ctgr_pkg::Q16One : g_sum[32:16];
            factors.blue <= row_last ? ctgr_pkg::Q16One : b_sum[32:16];
            state <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> busy)
    else $error("setup not busy after a register write");

  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !busy && !cfg_valid |=> $stable(step) && $stable(bright_eff) && $stable(factors))
    else $error("settings changed while idle");

  a_bright_range: assert property (@(posedge clk) disable iff (rst)
    bright_eff <= BMax)
    else $error("brightness above its limit");

endmodule
`default_nettype wire

// ===== rtl/core/ctgr_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctgr_pipe
// six-stage datapath: product, step product, reciprocal division by the
// brightness range with one correction, saturation, channel scaling; stalls
// as a whole with valid bits per stage
// ----------------------------------------------------------------------------
module ctgr_pipe #(
  parameter int BRIGHT_STEPS_MAX = 500
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              hold,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       entry_index,
  input  wire logic [15:0]       bright_eff,
  input  wire logic [16:0]       step,
  input  wire ctgr_pkg::factors_t factors,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [15:0]            red_level,
  output logic [15:0]            green_level,
  output logic [15:0]            blue_level
);

  localparam logic [15:0] Div = 16'(BRIGHT_STEPS_MAX);
  localparam logic [48:0] SatLim = 49'(64'(BRIGHT_STEPS_MAX) << 16);
  localparam logic [32:0] DivRecip = 33'((64'd1 << 32) / BRIGHT_STEPS_MAX);

  logic        v1, v2, v3, v4, v5, v6;
  logic [31:0] p1;
  logic [48:0] p2;
  logic        sat3, sat4;
  logic [31:0] n3;
  logic [15:0] qe3, qe4;
  logic [31:0] r4;
  logic [15:0] base;
  logic        adv;
  logic [64:0] recip_prod;
  logic [31:0] back_prod;
  logic [32:0] g_prod, b_prod;

  assign adv = !(v6 && out_stall);
  assign in_stall = !adv || hold;
  assign out_valid = v6;

  always_comb begin
    recip_prod = p2[31:0] * DivRecip;
    back_prod = qe3 * Div;
    g_prod = base * factors.green;
    b_prod = base * factors.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && !hold; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= entry_index * bright_eff;
      p2 <= p1 * step;
      sat3 <= (p2 >= SatLim);
      n3 <= p2[31:0];
      qe3 <= recip_prod[47:32];
      sat4 <= sat3;
      qe4 <= qe3;
      r4 <= n3 - back_prod;
      base <= sat4 ? 16'hFFFF : qe4 + {15'b0, (r4 >= {16'b0, Div})};
      red_level <= base;
      green_level <= g_prod[31:16];
      blue_level <= b_prod[31:16];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    v6 && out_stall |=> v6 && $stable(red_level) && $stable(green_level) &&
    $stable(blue_level))
    else $error("result lost under stall");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    hold |-> in_stall)
    else $error("input open while settings are updating");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted transaction missing from first stage");

endmodule
`default_nettype wire

// ===== rtl/core/color_temperature_gamma_ramp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// color_temperature_gamma_ramp
// One ramp entry per cycle while the output is not stalled and no setup
// update runs; a result is valid once its index has passed the pipeline, and
// a stalled output freezes the whole pipeline. A register write (and reset)
// restarts the setup unit, whose restoring divider for the ramp step sets its
// length: the input is stalled while the write is offered and until setup idles.
// ----------------------------------------------------------------------------
module color_temperature_gamma_ramp #(
  parameter int TABLE_ROWS       = 56,
  parameter int BRIGHT_STEPS_MAX = 500,
  parameter int KELVIN_LO        = 1000,
  parameter int KELVIN_HI        = 6500
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] entry_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      red_level,
  output logic [15:0]      green_level,
  output logic [15:0]      blue_level
);

  logic [15:0]        bright_eff;
  logic [16:0]        step;
  ctgr_pkg::factors_t factors;
  logic               busy;
  logic               hold;

  assign hold = busy | cfg_valid;

  ctgr_setup #(
    .TABLE_ROWS(TABLE_ROWS), .BRIGHT_STEPS_MAX(BRIGHT_STEPS_MAX),
    .KELVIN_LO(KELVIN_LO), .KELVIN_HI(KELVIN_HI)
  ) u_setup (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .bright_eff, .step, .factors, .busy
  );

  ctgr_pipe #(.BRIGHT_STEPS_MAX(BRIGHT_STEPS_MAX)) u_pipe (
    .clk, .rst, .hold, .in_valid, .in_stall, .entry_index, .bright_eff, .step,
    .factors, .out_valid, .out_stall, .red_level, .green_level, .blue_level
  );

endmodule
`default_nettype wire
